>>> rtl/tcw_pkg.sv
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // widths
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // character and attribute constants
  localparam logic [7:0] BLANK_CHAR      = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_COPY,
    S_BLANK,
    S_PUT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_data_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } out_data_t;

  // linear cursor position, masked to the result width
  function automatic logic [POS_W-1:0] cursor_pos(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return POS_W'(int'(row) * COLUMNS + int'(col));
  endfunction

  // store address of a cell on the visible screen
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

>>> rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/text_console_writer_top.sv
// channel   direction  handshake                 payload
// in_       input      in_valid / in_ready       tcw_pkg::in_data_t
// out_      output     out_valid / out_ready     tcw_pkg::out_data_t
// cfg_      input      cfg_wr_en (no wait)       cfg_wr_data, text attribute
//
// put character without scroll, newline and unused code finish in the accepting cycle; read cell adds S_READ
// clear screen takes the accepting cycle, then one cell a cycle over the whole store
// a put that scrolls: accept, copy every row up in S_COPY, blank the last row in S_BLANK, character write in S_PUT
// after reset every cell of the store is blanked before the first transaction
// a second result is held in a spare register, so a stalled output never loses one
module text_console_writer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_data_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  tcw_pkg::state_t state_r, state_nxt;

  logic [tcw_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [7:0]                attr_r;
  logic [7:0]                char_r, char_nxt;
  logic                      rd_zero_r, rd_zero_nxt;

  logic                      out_valid_r, pend_valid_r;
  tcw_pkg::out_data_t        out_data_r, pend_data_r;

  logic                       res_valid;
  tcw_pkg::out_data_t         res_data;
  logic [tcw_pkg::CELL_W-1:0] res_cell;

  logic                        ram_we, ram_re;
  logic [tcw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

  logic                        in_fire;
  logic                        is_newline, needs_scroll, idx_ok;
  logic [tcw_pkg::ROW_W-1:0]   put_row, row_sat;
  logic [tcw_pkg::COL_W:0]     col_inc;

  assign in_ready  = (state_r == tcw_pkg::S_IDLE) && !pend_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // screen store
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decode helpers
  assign is_newline   = (in_data.char_code == tcw_pkg::NEWLINE_CHAR);
  assign needs_scroll = (int'(row_r) >= tcw_pkg::ROWS);
  assign idx_ok       = (int'(in_data.cell_index) < tcw_pkg::CELL_COUNT);
  assign put_row      = (state_r == tcw_pkg::S_PUT) ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                                    : row_r;
  assign col_inc      = {1'b0, col_r} + 1'b1;
  assign row_sat      = (int'(row_r) < tcw_pkg::ROWS) ? row_r + 1'b1 : row_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::S_INIT: begin
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT - 1) state_nxt = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            tcw_pkg::OP_PUT: begin
              if (!is_newline && needs_scroll) state_nxt = tcw_pkg::S_COPY;
            end
            tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::S_CLEAR;
            tcw_pkg::OP_READ:  state_nxt = tcw_pkg::S_READ;
            default:           state_nxt = tcw_pkg::S_IDLE;
          endcase
        end
      end
      tcw_pkg::S_READ: state_nxt = tcw_pkg::S_IDLE;
      tcw_pkg::S_CLEAR: begin
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT - 1) state_nxt = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_COPY: begin
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT) state_nxt = tcw_pkg::S_BLANK;
      end
      tcw_pkg::S_BLANK: begin
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT - 1) state_nxt = tcw_pkg::S_PUT;
      end
      tcw_pkg::S_PUT: state_nxt = tcw_pkg::S_IDLE;
      default: state_nxt = tcw_pkg::S_IDLE;
    endcase
  end

  // memory accesses, cursor update and result
  always_comb begin
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    char_nxt    = char_r;
    rd_zero_nxt = rd_zero_r;
    ram_we      = 1'b0;
    ram_waddr   = tcw_pkg::ADDR_W'(cnt_r);
    ram_wdata   = {attr_r, tcw_pkg::BLANK_CHAR};
    ram_re      = 1'b0;
    ram_raddr   = tcw_pkg::ADDR_W'(cnt_r);
    res_valid   = 1'b0;
    res_cell    = '0;
    case (state_r)
      tcw_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {tcw_pkg::RESET_ATTRIBUTE, tcw_pkg::BLANK_CHAR};
        cnt_nxt   = cnt_r + 1'b1;
      end
      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          char_nxt = in_data.char_code;
          case (in_data.operation)
            tcw_pkg::OP_PUT: begin
              if (is_newline) begin
                row_nxt   = row_sat;
                col_nxt   = '0;
                res_valid = 1'b1;
              end else if (needs_scroll) begin
                cnt_nxt = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = tcw_pkg::cell_addr(put_row, col_r);
                ram_wdata = {attr_r, in_data.char_code};
                res_valid = 1'b1;
                if (int'(col_inc) >= tcw_pkg::COLUMNS) begin
                  row_nxt = put_row + 1'b1;
                  col_nxt = '0;
                end else begin
                  col_nxt = tcw_pkg::COL_W'(col_inc);
                end
              end
            end
            tcw_pkg::OP_CLEAR: cnt_nxt = '0;
            tcw_pkg::OP_READ: begin
              ram_re      = idx_ok;
              ram_raddr   = tcw_pkg::ADDR_W'(in_data.cell_index);
              rd_zero_nxt = !idx_ok;
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      tcw_pkg::S_READ: begin
        res_valid = 1'b1;
        res_cell  = rd_zero_r ? '0 : ram_rdata;
      end
      tcw_pkg::S_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT - 1) begin
          row_nxt   = '0;
          col_nxt   = '0;
          res_valid = 1'b1;
        end
      end
      tcw_pkg::S_COPY: begin
        // read one row below, write the cell read in the cycle before
        ram_re    = (int'(cnt_r) < tcw_pkg::CELL_COUNT);
        ram_we    = (int'(cnt_r) != tcw_pkg::COLUMNS);
        ram_waddr = tcw_pkg::ADDR_W'(cnt_r - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS + 1));
        ram_wdata = ram_rdata;
        cnt_nxt   = cnt_r + 1'b1;
        if (int'(cnt_r) == tcw_pkg::CELL_COUNT) begin
          cnt_nxt = tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
        end
      end
      tcw_pkg::S_BLANK: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      tcw_pkg::S_PUT: begin
        // character write on the last row after the scroll
        ram_we    = 1'b1;
        ram_waddr = tcw_pkg::cell_addr(put_row, col_r);
        ram_wdata = {attr_r, char_r};
        res_valid = 1'b1;
        row_nxt   = put_row;
        if (int'(col_inc) >= tcw_pkg::COLUMNS) begin
          row_nxt = put_row + 1'b1;
          col_nxt = '0;
        end else begin
          col_nxt = tcw_pkg::COL_W'(col_inc);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res_data.cursor_position = tcw_pkg::cursor_pos(row_nxt, col_nxt);
    res_data.cell_data       = res_cell;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::S_INIT;
      cnt_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      attr_r       <= tcw_pkg::RESET_ATTRIBUTE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      // output register with one spare slot
      if (!out_valid_r || out_ready) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= res_valid;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r    <= char_nxt;
    rd_zero_r <= rd_zero_nxt;
    if (!out_valid_r || out_ready) begin
      if (pend_valid_r) begin
        out_data_r  <= pend_data_r;
        pend_data_r <= res_data;
      end else begin
        out_data_r <= res_data;
      end
    end else if (res_valid) begin
      pend_data_r <= res_data;
    end
  end

  // checks
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) <= tcw_pkg::ROWS)
    else $error("cursor row beyond saturation value");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < tcw_pkg::COLUMNS)
    else $error("cursor column beyond last column");

  a_spare_order: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("spare result held while output register empty");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (int'(ram_waddr) < tcw_pkg::CELL_COUNT))
    else $error("screen write outside the store");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && pend_valid_r) |-> (!out_valid_r || out_ready))
    else $error("result produced with both output slots full");

  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == tcw_pkg::OP_CLEAR) |=> (state_r == tcw_pkg::S_CLEAR))
    else $error("clear transaction did not start the blanking sweep");

endmodule

>>> sim/text_console_writer_top_test.sv
`timescale 1ns / 100ps

module text_console_writer_top_test;

  // unused operation code, must change nothing
  localparam logic [1:0] OP_SPARE = 2'd3;
  // long receiver hold, enough to back the block up
  localparam int LONG_HOLD = 80;
  // cycles with no transaction on either side before giving up
  localparam int QUIET_LIMIT = 10000;
  localparam int PHASE_ITEMS = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tcw_pkg::in_data_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tcw_pkg::out_data_t out_data;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = '0;

  // screen image and cursor as the console should hold them
  logic [15:0] screen_img [tcw_pkg::CELL_COUNT];
  int          crow;
  int          ccol;
  logic [7:0]  attr_now;

  tcw_pkg::in_data_t  pending_items [$];
  tcw_pkg::out_data_t expected_results [$];

  bit idle_on = 1'b1;
  int holds_wanted = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  text_console_writer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // blank every cell with the current attribute
  function automatic void blank_screen();
    int i;
    for (i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_img[i] = {attr_now, tcw_pkg::BLANK_CHAR};
  endfunction

  // row saturates one past the bottom
  function automatic void next_row();
    if (crow < tcw_pkg::ROWS) crow++;
    ccol = 0;
  endfunction

  // apply one operation to the screen image and give the result it yields
  function automatic tcw_pkg::out_data_t console_predict(tcw_pkg::in_data_t item);
    tcw_pkg::out_data_t res;
    int                 i;
    res.cell_data = '0;
    case (item.operation)
      tcw_pkg::OP_PUT: begin
        if (item.char_code == tcw_pkg::NEWLINE_CHAR) begin
          next_row();
        end else begin
          // scroll up one row when the cursor sits past the bottom
          if (crow >= tcw_pkg::ROWS) begin
            for (i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
              screen_img[i] = screen_img[i + tcw_pkg::COLUMNS];
            for (i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
              screen_img[i] = {attr_now, tcw_pkg::BLANK_CHAR};
            crow = tcw_pkg::ROWS - 1;
          end
          screen_img[crow * tcw_pkg::COLUMNS + ccol] = {attr_now, item.char_code};
          ccol++;
          if (ccol >= tcw_pkg::COLUMNS) next_row();
        end
      end
      tcw_pkg::OP_CLEAR: begin
        blank_screen();
        crow = 0;
        ccol = 0;
      end
      tcw_pkg::OP_READ: begin
        if (item.cell_index < tcw_pkg::CELL_COUNT) res.cell_data = screen_img[item.cell_index];
      end
      default: begin
      end
    endcase
    res.cursor_position = tcw_pkg::POS_W'(crow * tcw_pkg::COLUMNS + ccol);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // item driver: offers queued transactions, with random gaps while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(console_predict(in_data));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // result monitor: checks each transaction and shapes out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, cursor %0d data 'h%h",
                                    out_data.cursor_position, out_data.cell_data));
        end else begin
          if (out_data.cursor_position !== expected_results[0].cursor_position)
            report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                      out_data.cursor_position,
                                      expected_results[0].cursor_position));
          if (out_data.cell_data !== expected_results[0].cell_data)
            report_mismatch($sformatf("cell_data got 'h%h expected 'h%h",
                                      out_data.cell_data, expected_results[0].cell_data));
          void'(expected_results.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != holds_wanted) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_writer_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // keep only a few transactions queued so near-cursor reads track the cursor
  task automatic offer(tcw_pkg::in_data_t item);
    while (pending_items.size() >= 4) @(posedge clk);
    pending_items.push_back(item);
  endtask

  function automatic tcw_pkg::in_data_t put_item(logic [7:0] code);
    tcw_pkg::in_data_t it;
    it = tcw_pkg::in_data_t'($urandom);
    it.operation = tcw_pkg::OP_PUT;
    it.char_code = code;
    return it;
  endfunction

  function automatic tcw_pkg::in_data_t read_item(int index);
    tcw_pkg::in_data_t it;
    it = tcw_pkg::in_data_t'($urandom);
    it.operation = tcw_pkg::OP_READ;
    it.cell_index = 11'(index);
    return it;
  endfunction

  function automatic tcw_pkg::in_data_t random_item();
    tcw_pkg::in_data_t it;
    int                roll;
    int                here;
    it = tcw_pkg::in_data_t'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      it.operation = tcw_pkg::OP_PUT;
      if ($urandom_range(0, 99) < 8) it.char_code = tcw_pkg::NEWLINE_CHAR;
    end else if (roll < 95) begin
      it.operation = tcw_pkg::OP_READ;
      roll = $urandom_range(0, 19);
      if (roll < 10) begin
        // recently written cells just behind the cursor
        here = crow * tcw_pkg::COLUMNS + ccol - $urandom_range(0, 160);
        if (here < 0) here = 0;
        if (here > tcw_pkg::CELL_COUNT - 1) here = tcw_pkg::CELL_COUNT - 1;
        it.cell_index = 11'(here);
      end else if (roll < 19) begin
        it.cell_index = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
      end else begin
        it.cell_index = 11'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
      end
    end else if (roll < 96) begin
      it.operation = tcw_pkg::OP_CLEAR;
    end else begin
      it.operation = OP_SPARE;
    end
    return it;
  endfunction

  // mostly text with newline runs and long wrapping lines
  task automatic run_random_phase(int count);
    int sent;
    int roll;
    int run_len;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        run_len = $urandom_range(5, 30);
        repeat (run_len) offer(put_item(tcw_pkg::NEWLINE_CHAR));
      end else if (roll < 4) begin
        run_len = $urandom_range(40, 120);
        repeat (run_len) offer(put_item(8'($urandom_range(32, 126))));
      end else begin
        run_len = 1;
        offer(random_item());
      end
      sent += run_len;
    end
  endtask

  // sender pause until every result is back and the block has settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    attr_now = value;
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    tcw_pkg::in_data_t spare;
    int                p;
    attr_now = tcw_pkg::RESET_ATTRIBUTE;
    blank_screen();
    crow = 0;
    ccol = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents, store edges and out-of-range reads
    offer(read_item(0));
    offer(read_item(tcw_pkg::CELL_COUNT - 1));
    offer(read_item(tcw_pkg::CELL_COUNT));
    offer(read_item(2047));
    spare = tcw_pkg::in_data_t'($urandom);
    spare.operation = OP_SPARE;
    offer(spare);
    // character extremes, high bit must not leak into the attribute
    offer(put_item(8'h00));
    offer(put_item(8'hFF));
    offer(put_item(8'h80));
    offer(read_item(1));
    offer(read_item(2));
    // run the row past the bottom, then a put that scrolls
    repeat (tcw_pkg::ROWS + 1) offer(put_item(tcw_pkg::NEWLINE_CHAR));
    offer(put_item("Z"));
    offer(read_item((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS));
    offer(read_item(0));
    spare = tcw_pkg::in_data_t'($urandom);
    spare.operation = tcw_pkg::OP_CLEAR;
    offer(spare);
    offer(read_item(2));
    wait_drained();

    for (p = 1; p <= 4; p++) begin
      case (p)
        1: write_attribute(8'hFF);
        2: write_attribute(8'h00);
        default: write_attribute(8'($urandom));
      endcase
      if (p == 2) holds_wanted++;
      if (p == 4) idle_on = 1'b0;
      run_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("text_console_writer_top regression: pass");
    end else begin
      $display("text_console_writer_top regression: fail");
    end
    $finish;
  end

endmodule
